@@ hdl/stbs_pkg.sv @@
// Shared types and constants for the sorted table binary search block.
// Depends on nothing; every other file of the block imports it.
package stbs_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRIES_W   = 9;

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [7:0]         entry_index;
      logic signed [31:0] entry_value;
      logic signed [31:0] search_key;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [7:0] position;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic write;
      logic load;
      logic step;
      logic capture_hit;
      logic capture_miss;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;
      logic hit;
      logic more;
   } stat_type;

endpackage

@@ hdl/stbs_datapath.sv @@
// Datapath of the binary search: table memory, search bounds, compare and result register.
// Depends on stbs_pkg.
module stbs_datapath
   import stbs_pkg::*;
(
   input  logic                 clock,
   input  req_type              req,
   input  logic                 csr_write_enable,
   input  logic [ENTRIES_W-1:0] csr_write_data,
   input  cmd_type              cmd,
   output stat_type             stat,
   output rsp_type              rsp,
   input  logic                 reset
);

   logic signed [31:0]   table_mem [TABLE_DEPTH];
   logic signed [31:0]   rd_data_ff;
   logic signed [31:0]   key_ff;
   logic [ENTRIES_W-1:0] entries_ff;
   logic [CNT_W-1:0]     lo_ff, lo_in;
   logic [CNT_W-1:0]     hi_ff, hi_in;
   logic [IDX_W-1:0]     mid_ff;
   logic [IDX_W-1:0]     first_mid, next_mid, rd_addr;
   logic [CNT_W-1:0]     n_sat;
   logic [CNT_W:0]       first_sum, next_sum;
   logic                 wr_in_range;
   logic                 key_above;
   rsp_type              rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '0;
      end else if (csr_write_enable) begin
         entries_ff <= csr_write_data;
      end
   end

   always_comb begin
      if (32'(entries_ff) > 32'(TABLE_DEPTH)) begin
         n_sat = CNT_W'(TABLE_DEPTH);
      end else begin
         n_sat = CNT_W'(entries_ff);
      end
      first_sum = {1'b0, n_sat} - (CNT_W+1)'(1);
      first_mid = IDX_W'(first_sum >> 1);

      // Narrow the half-open range around the entry just read.
      key_above = rd_data_ff < key_ff;
      lo_in     = key_above ? (CNT_W'(mid_ff) + CNT_W'(1)) : lo_ff;
      hi_in     = key_above ? hi_ff : CNT_W'(mid_ff);
      next_sum  = {1'b0, lo_in} + {1'b0, hi_in} - (CNT_W+1)'(1);
      next_mid  = IDX_W'(next_sum >> 1);

      rd_addr     = cmd.load ? first_mid : next_mid;
      wr_in_range = 32'(req.entry_index) < 32'(TABLE_DEPTH);

      stat.empty = n_sat == '0;
      stat.hit   = rd_data_ff == key_ff;
      stat.more  = lo_in < hi_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.write && wr_in_range) begin
         table_mem[IDX_W'(req.entry_index)] <= req.entry_value;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= table_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= req.search_key;
         lo_ff  <= '0;
         hi_ff  <= n_sat;
         mid_ff <= first_mid;
      end else if (cmd.step) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         mid_ff <= next_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture_hit) begin
         rsp_ff.found    <= 1'b1;
         rsp_ff.position <= 8'(mid_ff);
      end else if (cmd.capture_miss) begin
         rsp_ff.found    <= 1'b0;
         rsp_ff.position <= '0;
      end
   end

   assign rsp = rsp_ff;

endmodule

@@ hdl/stbs_ctrl.sv @@
// Controller state machine of the binary search: accepts transactions and sequences probes.
// Depends on stbs_pkg.
module stbs_ctrl
   import stbs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     kind,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy,
   output logic     rsp_strobe
);

   typedef enum logic {
      ST_IDLE,
      ST_PROBE
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      strobe_ff;
   logic      accept;

   assign accept = start && !busy_ff;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.write        = accept && (kind == KIND_WRITE);
            cmd.load         = accept && (kind == KIND_SEARCH) && !stat.empty;
            cmd.capture_miss = accept && (kind == KIND_SEARCH) && stat.empty;
         end
         ST_PROBE: begin
            cmd.capture_hit  = stat.hit;
            cmd.capture_miss = !stat.hit && !stat.more;
            cmd.step         = !stat.hit && stat.more;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.capture_hit || cmd.capture_miss;
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.load) begin
                  state_ff <= ST_PROBE;
                  busy_ff  <= 1'b1;
               end
            end
            ST_PROBE: begin
               if (!cmd.step) begin
                  state_ff <= ST_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

@@ hdl/sorted_table_binary_search_top.sv @@
// Top level of the sorted table binary search block.
// Depends on stbs_pkg, stbs_ctrl and stbs_datapath.
//
// Usage: a request transaction is accepted at a rising clock edge where start is
// high and busy is low. A write transaction (kind 0) stores entry_value at
// entry_index and produces no response; indexes beyond the table
// are dropped. A search transaction (kind 1) looks for search_key among the
// first entries_in_use entries, which software must have loaded in ascending order.
// The csr port writes entries_in_use; values above the table depth saturate.
// Each probe compares search_key with the registered read of the table memory.
// A search takes between 1 and 9 probes for a 256-entry table, and its response
// is registered from the compare of the last probe; busy is high while the
// probes run. An empty table answers not found without a probe, and busy
// stays low.
// Each response transaction stands on rsp for exactly one cycle with rsp_strobe
// high; the receiver cannot stall it. Reset clears the state machine and the
// entries_in_use register; table contents are undefined until written.
module sorted_table_binary_search_top
   import stbs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req,
   output logic                 rsp_strobe,
   output rsp_type              rsp,
   input  logic                 csr_write_enable,
   input  logic [ENTRIES_W-1:0] csr_write_data
);

   // Command and status groups that join the controller and the datapath.
   cmd_type  cmd;
   stat_type stat;

   stbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .kind       (req.kind),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // The datapath holds the table, the bounds of the current search and the
   // response register that the controller loads at the end of a search.
   stbs_datapath u_datapath (
      .clock            (clock),
      .req              (req),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .stat             (stat),
      .rsp              (rsp),
      .reset            (reset)
   );

endmodule
